// ===== hw/rtl/blackman_sinc_lowpass_coefficients_top_macros.svh =====
// Assertion macros for the windowed-sinc tap generator.
`ifndef BLACKMAN_SINC_LOWPASS_COEFFICIENTS_TOP_MACROS_SVH
`define BLACKMAN_SINC_LOWPASS_COEFFICIENTS_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// Check a condition at every clock edge outside reset.
`define BSLC_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("bslc assertion failed");
// Check that a condition implies another one on the next clock edge.
`define BSLC_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("bslc assertion failed");
`else
`define BSLC_ASSERT(lbl, cond)
`define BSLC_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

// ===== hw/rtl/bslc_pkg.sv =====
`timescale 1ns / 1ps
package bslc_pkg;

  localparam int CORDIC_STEPS = 30;
  localparam int DW           = 34;   // CORDIC and datapath word, Q2.30 plus headroom
  localparam int PW           = 2 * DW;
  localparam int DIV_W        = 40;   // dividend width of the serial divider

  localparam logic signed [DW-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [DW-1:0] INV_PI_Q32  = 34'sd1367130551;
  localparam logic signed [DW-1:0] WIN_A0      = 34'sd450971566;
  localparam logic signed [DW-1:0] WIN_A2      = 34'sd85899346;

  localparam logic CFG_CUTOFF = 1'b0;
  localparam logic CFG_TAPS   = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SIN_COR,
    ST_SIN_MUL,
    ST_SIN_DIV,
    ST_W1_DIV,
    ST_W1_COR,
    ST_W2_DIV,
    ST_W2_COR,
    ST_WIN_MUL,
    ST_WIN_SUM,
    ST_TAP_MUL,
    ST_ROUND,
    ST_EMIT
  } seq_state_t;

  // Arctangent of 2^-k in turns scaled by 2^32.
  function automatic logic [29:0] atan_turn(input logic [4:0] k);
    logic [29:0] v;
    case (k)
      5'd0:  v = 30'h20000000;
      5'd1:  v = 30'h12E4051E;
      5'd2:  v = 30'h09FB385B;
      5'd3:  v = 30'h051111D4;
      5'd4:  v = 30'h028B0D43;
      5'd5:  v = 30'h0145D7E1;
      5'd6:  v = 30'h00A2F61E;
      5'd7:  v = 30'h00517C55;
      5'd8:  v = 30'h0028BE53;
      5'd9:  v = 30'h00145F2F;
      5'd10: v = 30'h000A2F98;
      5'd11: v = 30'h000517CC;
      5'd12: v = 30'h00028BE6;
      5'd13: v = 30'h000145F3;
      5'd14: v = 30'h0000A2FA;
      5'd15: v = 30'h0000517D;
      5'd16: v = 30'h000028BE;
      5'd17: v = 30'h0000145F;
      5'd18: v = 30'h00000A30;
      5'd19: v = 30'h00000518;
      5'd20: v = 30'h0000028C;
      5'd21: v = 30'h00000146;
      5'd22: v = 30'h000000A3;
      5'd23: v = 30'h00000051;
      5'd24: v = 30'h00000029;
      5'd25: v = 30'h00000014;
      5'd26: v = 30'h0000000A;
      5'd27: v = 30'h00000005;
      5'd28: v = 30'h00000003;
      5'd29: v = 30'h00000001;
      default: v = 30'h0;
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/bslc_if.sv =====
`timescale 1ns / 1ps
interface bslc_req_if;
  logic valid;
  logic ready;
  logic start_req;
  modport source (output valid, output start_req, input ready);
  modport sink (input valid, input start_req, output ready);
endinterface

interface bslc_tap_if;
  logic               valid;
  logic               ready;
  logic [5:0]         tap_index;
  logic signed [15:0] coefficient;
  logic               last;
  modport source (output valid, output tap_index, output coefficient, output last,
                  input ready);
  modport sink (input valid, input tap_index, input coefficient, input last,
                output ready);
endinterface

// ===== hw/rtl/bslc_cordic.sv =====
`timescale 1ns / 1ps
module bslc_cordic
  import bslc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [31:0]          phase,
  output logic                 done_r,
  output logic signed [DW-1:0] sin_r,
  output logic signed [DW-1:0] cos_r
);

  logic signed [DW-1:0] x_r, y_r, a_r;
  logic [4:0]           k_r;
  logic                 busy_r, flip_r;
  logic signed [DW-1:0] a0, a_fold, x_nxt, y_nxt, a_nxt, atan_s;
  logic                 flip_nxt;

  // Fold the 2nd and 3rd quadrants by a half turn
  always_comb begin
    a0 = DW'($signed(phase));
    if (a0 > 34'sh040000000) begin
      a_fold = a0 - 34'sh080000000;
      flip_nxt = 1'b1;
    end else if (a0 < -34'sh040000000) begin
      a_fold = a0 + 34'sh080000000;
      flip_nxt = 1'b1;
    end else begin
      a_fold = a0;
      flip_nxt = 1'b0;
    end
  end

  // One rotation step
  always_comb begin
    atan_s = DW'($signed({1'b0, atan_turn(k_r)}));
    if (a_r >= 0) begin
      x_nxt = x_r - (y_r >>> k_r);
      y_nxt = y_r + (x_r >>> k_r);
      a_nxt = a_r - atan_s;
    end else begin
      x_nxt = x_r + (y_r >>> k_r);
      y_nxt = y_r - (x_r >>> k_r);
      a_nxt = a_r + atan_s;
    end
  end

  // Control: launch, count steps, flag completion
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      k_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        k_r    <= '0;
      end else if (busy_r) begin
        k_r <= k_r + 5'd1;
        if (k_r == 5'(CORDIC_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= CORDIC_GAIN;
      y_r    <= '0;
      a_r    <= a_fold;
      flip_r <= flip_nxt;
    end else if (busy_r) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      a_r <= a_nxt;
      if (k_r == 5'(CORDIC_STEPS - 1)) begin
        sin_r <= flip_r ? -y_nxt : y_nxt;
        cos_r <= flip_r ? -x_nxt : x_nxt;
      end
    end
  end

endmodule

// ===== hw/rtl/bslc_div.sv =====
`timescale 1ns / 1ps
module bslc_div
  import bslc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [6:0]       divisor,
  output logic             done_r,
  output logic [DIV_W-1:0] quot_r
);

  localparam int CW = $clog2(DIV_W);

  logic [DIV_W-1:0] num_r;
  logic [6:0]       rem_r;
  logic [6:0]       dsr_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r;
  logic [7:0]       trial;
  logic             qbit;
  logic [6:0]       rem_nxt;

  // Restoring step: one quotient bit per cycle
  always_comb begin
    trial = {rem_r, num_r[DIV_W-1]};
    qbit  = (trial >= {1'b0, dsr_r});
    rem_nxt = qbit ? 7'(trial - {1'b0, dsr_r}) : trial[6:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r  <= {num_r[DIV_W-2:0], 1'b0};
      rem_r  <= rem_nxt;
      quot_r <= {quot_r[DIV_W-2:0], qbit};
    end
  end

endmodule

// ===== hw/rtl/blackman_sinc_lowpass_coefficients_top.sv =====
`timescale 1ns / 1ps
// Blackman-windowed sinc lowpass tap generator. A request transaction with
// start_req set makes the block emit N taps (N = tap_count clamped to 2..MAX_TAPS)
// in order, each sinc(i-(N-1)/2) times an N-point Blackman window, as signed
// Q1.15 with saturation; last marks the final tap. start_req clear is consumed
// with no output. The block takes no request until the final tap is taken.
// Each tap runs a serial 40-bit divider and a 30-step CORDIC three times each
// (twice each for the centre tap), plus setup, multiply, window-sum and rounding
// states; a tap waits in the emit state while the output stalls.
// Write cutoff_norm (index 0) and tap_count (index 1) only while idle.
module blackman_sinc_lowpass_coefficients_top
  import bslc_pkg::*;
#(
  parameter int MAX_TAPS       = 64,
  parameter int COEF_FRAC_BITS = 15
) (
  input  logic        clk,
  input  logic        rst_n,
  bslc_req_if.sink    in_ch,
  bslc_tap_if.source  out_ch,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);

`include "blackman_sinc_lowpass_coefficients_top_macros.svh"

  localparam int SH = 60 - COEF_FRAC_BITS;
  localparam logic signed [PW-1:0] RND_TAP = PW'(1) <<< (SH - 1);
  localparam logic signed [PW-1:0] RND_WIN = PW'(1) <<< 29;

  seq_state_t state_r, state_nxt;
  logic       go_r;

  logic [15:0] cutoff_r;
  logic [6:0]  taps_r;
  logic [5:0]  m_r, i_r;
  logic signed [7:0] d2;
  logic [6:0]  abs_d2;
  logic signed [DW-1:0] s_r, c1_r, sinc_r, w_r;
  logic signed [PW-1:0] mul_r, op_prod;
  logic signed [DW-1:0] op_a, op_b;
  logic        neg_r;
  logic signed [15:0] coef_r;
  logic [6:0]  n_clamp;

  logic              cor_start, cor_done;
  logic [31:0]       cor_phase;
  logic signed [DW-1:0] cor_sin, cor_cos;
  logic              div_start, div_done;
  logic [DIV_W-1:0]  div_num, div_quot;
  logic [6:0]        div_den;

  logic signed [24:0] ph_prod;
  logic [PW-1:0]      p_abs;
  logic [PW-1:0]      x_sum;
  logic signed [PW-1:0] w_sum, v_round;
  logic               in_acc, out_acc;

  assign in_acc  = in_ch.valid & in_ch.ready;
  assign out_acc = out_ch.valid & out_ch.ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cutoff_r <= 16'd8192;
      taps_r   <= 7'd31;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CUTOFF: cutoff_r <= cfg_wdata;
        CFG_TAPS:   taps_r   <= cfg_wdata[6:0];
        default:    ;
      endcase
    end
  end

  // Clamp the tap count
  always_comb begin
    if (taps_r < 7'd2) n_clamp = 7'd2;
    else if (taps_r > 7'(MAX_TAPS)) n_clamp = 7'(MAX_TAPS);
    else n_clamp = taps_r;
  end

  // Tap geometry and sinc phase
  assign d2      = $signed({1'b0, i_r, 1'b0}) - $signed({2'b00, m_r});
  assign abs_d2  = d2[7] ? 7'(-d2) : d2[6:0];
  assign ph_prod = $signed({1'b0, cutoff_r}) * d2;

  // Shared multiplier operand select
  always_comb begin
    case (state_r)
      ST_SIN_MUL: begin op_a = s_r;    op_b = INV_PI_Q32; end
      ST_WIN_MUL: begin op_a = WIN_A2; op_b = cor_cos;    end
      default:    begin op_a = sinc_r; op_b = w_r;        end
    endcase
  end
  assign op_prod = op_a * op_b;

  // Magnitude and pre-scaled dividend for the sinc division, window sum and rounded tap
  assign p_abs   = mul_r[PW-1] ? PW'(-mul_r) : PW'(mul_r);
  assign x_sum   = (p_abs + (PW'(abs_d2) << 30)) >> 31;
  assign w_sum   = PW'(WIN_A0) - PW'(c1_r >>> 1) + ((mul_r + RND_WIN) >>> 30);
  assign v_round = (mul_r + RND_TAP) >>> SH;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:    if (in_acc && in_ch.start_req) state_nxt = ST_SETUP;
      ST_SETUP:   state_nxt = (d2 == 8'sd0) ? ST_W1_DIV : ST_SIN_COR;
      ST_SIN_COR: if (cor_done) state_nxt = ST_SIN_MUL;
      ST_SIN_MUL: state_nxt = ST_SIN_DIV;
      ST_SIN_DIV: if (div_done) state_nxt = ST_W1_DIV;
      ST_W1_DIV:  if (div_done) state_nxt = ST_W1_COR;
      ST_W1_COR:  if (cor_done) state_nxt = ST_W2_DIV;
      ST_W2_DIV:  if (div_done) state_nxt = ST_W2_COR;
      ST_W2_COR:  if (cor_done) state_nxt = ST_WIN_MUL;
      ST_WIN_MUL: state_nxt = ST_WIN_SUM;
      ST_WIN_SUM: state_nxt = ST_TAP_MUL;
      ST_TAP_MUL: state_nxt = ST_ROUND;
      ST_ROUND:   state_nxt = ST_EMIT;
      ST_EMIT:    if (out_acc) state_nxt = (i_r == m_r) ? ST_IDLE : ST_SETUP;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Unit launches and port outputs
  always_comb begin
    cor_start = 1'b0;
    cor_phase = div_quot[31:0];
    div_start = 1'b0;
    div_num   = (DIV_W'(i_r) << 32) + DIV_W'(m_r >> 1);
    div_den   = {1'b0, m_r};
    case (state_r)
      ST_SIN_COR: begin
        cor_start = go_r;
        cor_phase = {ph_prod[16:0], 15'd0};
      end
      ST_SIN_DIV: begin
        div_start = go_r;
        div_num   = x_sum[DIV_W-1:0];
        div_den   = abs_d2;
      end
      ST_W1_DIV: div_start = go_r;
      ST_W2_DIV: begin
        div_start = go_r;
        div_num   = (DIV_W'(i_r) << 33) + DIV_W'(m_r >> 1);
      end
      ST_W1_COR, ST_W2_COR: cor_start = go_r;
      default: ;
    endcase
    in_ch.ready        = (state_r == ST_IDLE);
    out_ch.valid       = (state_r == ST_EMIT);
    out_ch.tap_index   = i_r;
    out_ch.coefficient = coef_r;
    out_ch.last        = (i_r == m_r);
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      go_r    <= 1'b0;
      i_r     <= '0;
      m_r     <= '0;
    end else begin
      state_r <= state_nxt;
      go_r    <= (state_nxt != state_r);
      if (state_r == ST_IDLE && in_acc) begin
        i_r <= '0;
        m_r <= 6'(n_clamp - 7'd1);
      end else if (state_r == ST_EMIT && out_acc) begin
        i_r <= i_r + 6'd1;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_SETUP: if (d2 == 8'sd0) sinc_r <= DW'({cutoff_r, 15'd0});
      ST_SIN_COR: if (cor_done) s_r <= cor_sin;
      ST_SIN_MUL: mul_r <= op_prod;
      ST_SIN_DIV: begin
        if (go_r) neg_r <= mul_r[PW-1] ^ d2[7];
        if (div_done) sinc_r <= neg_r ? -DW'(div_quot) : DW'(div_quot);
      end
      ST_W1_COR: if (cor_done) c1_r <= cor_cos;
      ST_WIN_MUL: mul_r <= op_prod;
      ST_WIN_SUM: w_r <= w_sum[DW-1:0];
      ST_TAP_MUL: mul_r <= op_prod;
      ST_ROUND: begin
        if (v_round > PW'(32767)) coef_r <= 16'sh7FFF;
        else if (v_round < -PW'(32768)) coef_r <= 16'sh8000;
        else coef_r <= v_round[15:0];
      end
      default: ;
    endcase
  end

  bslc_cordic u_cordic (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cor_start),
    .phase  (cor_phase),
    .done_r (cor_done),
    .sin_r  (cor_sin),
    .cos_r  (cor_cos)
  );

  bslc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .done_r   (div_done),
    .quot_r   (div_quot)
  );

  `BSLC_ASSERT(a_ready_excl, !(in_ch.ready && out_ch.valid))
  `BSLC_ASSERT(a_last_index, !(out_ch.valid && out_ch.last) || (out_ch.tap_index == m_r))
  `BSLC_ASSERT_NEXT(a_idle_after_last, out_acc && out_ch.last, in_ch.ready)

endmodule

// ===== bench/tb_blackman_sinc_lowpass_coefficients_top.sv =====
`timescale 1ns / 1ps
module tb_blackman_sinc_lowpass_coefficients_top;
  import bslc_pkg::*;

  typedef struct {
    logic [5:0]         tap_index;
    logic signed [15:0] coefficient;
    logic               last;
  } tap_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_wdata;

  bslc_req_if in_if();
  bslc_tap_if out_if();

  blackman_sinc_lowpass_coefficients_top u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_if.sink),
    .out_ch   (out_if.source),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // Shadow copy of the configuration registers
  logic [15:0] cutoff_shadow;
  logic [6:0]  taps_shadow;

  logic   start_queue[$];
  tap_t   expected_taps[$];
  int     error_count;
  int     tap_total;
  int     run_total;
  int     burst_left;
  int     gap_left;
  int     stall_mode;
  int     stall_left;

  longint atan_tab[30] = '{
    'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
    'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
    'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D, 'h000028BE, 'h0000145F,
    'h00000A30, 'h00000518, 'h0000028C, 'h00000146, 'h000000A3, 'h00000051,
    'h00000029, 'h00000014, 'h0000000A, 'h00000005, 'h00000003, 'h00000001
  };

  always #2 clk = ~clk;

  // Rotate a 32-bit phase (one turn = 2^32) to Q30 sine and cosine
  function automatic void cordic_sincos(input logic [31:0] phase, output longint s,
                                        output longint c);
    longint a;
    longint x;
    longint y;
    longint dx;
    longint dy;
    bit     flip;
    a = phase;
    if (a >= 64'sh80000000) a = a - 64'sh100000000;
    flip = 0;
    x = 652032874;
    y = 0;
    if (a > 64'sh40000000) begin
      a = a - 64'sh80000000;
      flip = 1;
    end else if (a < -64'sh40000000) begin
      a = a + 64'sh80000000;
      flip = 1;
    end
    for (int k = 0; k < 30; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (a >= 0) begin
        x = x - dx; y = y + dy; a = a - atan_tab[k];
      end else begin
        x = x + dx; y = y - dy; a = a + atan_tab[k];
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    s = y;
    c = x;
  endfunction

  function automatic logic [31:0] win_phase(input longint k, input longint i, input longint m);
    longint unsigned num;
    num = (longint'(k * i) << 32) + longint'(m / 2);
    return 32'(num / longint'(m));
  endfunction

  // Compute one tap of an n-tap filter in Q1.15 with saturation
  function automatic logic signed [15:0] tap_coef(input longint i, input longint n);
    longint          m;
    longint          d2;
    longint          sinc;
    longint          s;
    longint          c1;
    longint          c2;
    longint          unused;
    longint          w;
    longint          v;
    longint unsigned un;
    longint unsigned ud;
    longint unsigned q;
    longint unsigned u;
    logic [31:0]     ph;
    m = n - 1;
    d2 = 2 * i - m;
    if (d2 == 0) begin
      sinc = longint'(cutoff_shadow) << 15;
    end else begin
      u = longint'(cutoff_shadow) * d2;
      ph = 32'(u << 15);
      cordic_sincos(ph, s, unused);
      s = s * 1367130551;
      un = (s < 0) ? -s : s;
      ud = (d2 < 0) ? -(d2 * 64'sh80000000) : d2 * 64'sh80000000;
      q = (un + ud / 2) / ud;
      sinc = ((s < 0) != (d2 < 0)) ? -longint'(q) : longint'(q);
    end
    cordic_sincos(win_phase(1, i, m), unused, c1);
    cordic_sincos(win_phase(2, i, m), unused, c2);
    w = 450971566 - (c1 >>> 1) + ((85899346 * c2 + 64'sh20000000) >>> 30);
    v = (sinc * w + (64'sd1 <<< 44)) >>> 45;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  // Expand one accepted request into its full tap set (none when start is clear)
  task automatic predict_taps(input logic start);
    longint n;
    tap_t   t;
    if (!start) return;
    n = taps_shadow;
    if (n < 2) n = 2;
    if (n > 64) n = 64;
    for (longint i = 0; i < n; i++) begin
      t.tap_index   = 6'(i);
      t.coefficient = tap_coef(i, n);
      t.last        = (i == n - 1);
      expected_taps.push_back(t);
    end
    run_total++;
  endtask

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    error_count++;
  endtask

  // Driver: send requests in bursts separated by random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) predict_taps(in_if.start_req);
      if (!in_if.valid || in_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_if.valid <= 1'b0;
        end else if (start_queue.size() > 0) begin
          in_if.valid     <= 1'b1;
          in_if.start_req <= start_queue.pop_front();
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 4);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each tap transaction and stall the result channel
  always @(posedge clk) begin
    tap_t e;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        tap_total++;
        if (expected_taps.size() == 0) begin
          report_mismatch($sformatf("unexpected tap index %0d", out_if.tap_index));
        end else begin
          e = expected_taps.pop_front();
          if (out_if.tap_index !== e.tap_index)
            report_mismatch($sformatf("tap_index %0d, want %0d", out_if.tap_index,
                                      e.tap_index));
          if (out_if.coefficient !== e.coefficient)
            report_mismatch($sformatf("tap %0d coefficient %0d, want %0d", e.tap_index,
                                      out_if.coefficient, e.coefficient));
          if (out_if.last !== e.last)
            report_mismatch($sformatf("tap %0d last %0b, want %0b", e.tap_index,
                                      out_if.last, e.last));
        end
      end
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_left = $urandom_range(20, 400);
      end else begin
        stall_left--;
      end
      case (stall_mode)
        0: begin
          out_if.ready <= 1'b1;
        end
        1: begin
          out_if.ready <= ($urandom_range(0, 3) != 0);
        end
        default: begin
          out_if.ready <= ($urandom_range(0, 7) == 0);
        end
      endcase
    end
  end

  // Wait until the block is drained, then give it time to settle
  task automatic wait_idle();
    while (start_queue.size() > 0 || in_if.valid || expected_taps.size() > 0)
      @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_cfg(input logic idx, input logic [15:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == CFG_CUTOFF) cutoff_shadow = data;
    else taps_shadow = data[6:0];
  endtask

  task automatic run_phase(input logic [15:0] cutoff, input logic [6:0] taps,
                           input int starts, input int idles);
    wait_idle();
    write_cfg(CFG_CUTOFF, cutoff);
    write_cfg(CFG_TAPS, {9'd0, taps});
    for (int k = 0; k < idles; k++) start_queue.push_back(1'b0);
    for (int k = 0; k < starts; k++) start_queue.push_back(1'b1);
  endtask

  initial begin
    int          starts_sent;
    int          n;
    logic [15:0] cut;
    logic [6:0]  taps;
    clk             = 1'b0;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = 1'b0;
    cfg_wdata       = 16'd0;
    in_if.valid     = 1'b0;
    in_if.start_req = 1'b0;
    out_if.ready    = 1'b0;
    cutoff_shadow   = 16'd8192;
    taps_shadow     = 7'd31;
    error_count     = 0;
    tap_total       = 0;
    run_total       = 0;
    burst_left      = 0;
    gap_left        = 0;
    stall_mode      = 0;
    stall_left      = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset defaults, including a request with start clear
    start_queue.push_back(1'b0);
    start_queue.push_back(1'b1);
    // Directed corners: clamped tap counts, odd and even lengths, cutoff extremes
    run_phase(16'd0, 7'd0, 1, 1);
    run_phase(16'd32768, 7'd64, 1, 0);
    run_phase(16'd65535, 7'd127, 1, 0);
    run_phase(16'd1, 7'd1, 2, 1);
    run_phase(16'd16384, 7'd2, 2, 0);
    run_phase(16'd32767, 7'd33, 1, 0);
    run_phase(16'd40000, 7'd12, 1, 1);
    run_phase(16'd5461, 7'd65, 1, 0);
    run_phase(16'd10923, 7'd3, 2, 0);
    starts_sent = 13;

    // Random phases: mostly short filters, now and then long or clamped ones
    while (starts_sent < 140) begin
      cut  = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768));
      taps = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(13, 127))
                                          : 7'($urandom_range(0, 12));
      wait_idle();
      write_cfg(CFG_CUTOFF, cut);
      write_cfg(CFG_TAPS, {9'd0, taps});
      n = $urandom_range(3, 12);
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(0, 7) == 0) begin
          start_queue.push_back(1'b0);
        end else begin
          start_queue.push_back(1'b1);
          starts_sent++;
        end
      end
    end

    wait_idle();
    repeat (300) @(posedge clk);
    $display("Covered %0d tap runs, %0d taps checked, cutoff 0..65535, tap count 0..127.",
             run_total, tap_total);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", error_count);
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Hard stop if the block hangs
  initial begin
    #80ms;
    $display("Timeout with %0d taps still expected", expected_taps.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/bslc_pkg.sv
hw/rtl/bslc_if.sv
hw/rtl/bslc_cordic.sv
hw/rtl/bslc_div.sv
hw/rtl/blackman_sinc_lowpass_coefficients_top.sv
bench/tb_blackman_sinc_lowpass_coefficients_top.sv
